// ----- rtl/core/footswitch_chord_event_engine_defines.svh -----
// Assertion macros shared by the assertions of the footswitch chord event engine checker.
`ifndef FOOTSWITCH_CHORD_EVENT_ENGINE_DEFINES_SVH
`define FOOTSWITCH_CHORD_EVENT_ENGINE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- rtl/core/fce_pkg.sv -----
// Package with types, codes and constants of the footswitch chord event engine.
`timescale 1ns / 1ps
package fce_pkg;
   localparam int MaxRepeatsDefault = 16;
   localparam int ResultLimit = 16;
   localparam int RegCount = 6;

   localparam logic [2:0] EV_PRESS         = 3'd0;
   localparam logic [2:0] EV_DOUBLE        = 3'd1;
   localparam logic [2:0] EV_RELEASE       = 3'd2;
   localparam logic [2:0] EV_LONG          = 3'd3;
   localparam logic [2:0] EV_CHORD_PRESS   = 3'd4;
   localparam logic [2:0] EV_CHORD_REPEAT  = 3'd5;
   localparam logic [2:0] EV_CHORD_RELEASE = 3'd6;

   localparam logic [2:0] REG_DEBOUNCE = 3'd0;
   localparam logic [2:0] REG_DTAP     = 3'd1;
   localparam logic [2:0] REG_WINDOW   = 3'd2;
   localparam logic [2:0] REG_LONG     = 3'd3;
   localparam logic [2:0] REG_RDELAY   = 3'd4;
   localparam logic [2:0] REG_RINTV    = 3'd5;

   localparam logic [3:0] MASK_AC = 4'b0101;
   localparam logic [3:0] MASK_BD = 4'b1010;
   localparam logic [3:0] MASK_AB = 4'b0011;
   localparam logic [3:0] MASK_CD = 4'b1100;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] double_tap_gap;
      logic [15:0] chord_window;
      logic [15:0] long_press_time;
      logic [15:0] repeat_delay;
      logic [15:0] repeat_interval;
   } cfg_type;

   // Sequencer states; the switch walks reuse one state with a counter.
   typedef enum logic [3:0] {
      ST_IDLE, ST_RAW, ST_DEB, ST_CHORD, ST_REPEAT, ST_WINDOW,
      ST_PRESS, ST_DTAP, ST_REL, ST_LONG, ST_ADDED, ST_EMIT, ST_DONE
   } state_type;

   // Compare unit operations.
   typedef enum logic [1:0] {
      CMP_WAITED, CMP_REACHED, CMP_LESS
   } cmp_op_type;

   function automatic logic [2:0] pair_code(input logic [3:0] m);
      logic [2:0] c;
      c = 3'd0;
      if (m == MASK_AC) c = 3'd1;
      else if (m == MASK_BD) c = 3'd2;
      else if (m == MASK_AB) c = 3'd3;
      else if (m == MASK_CD) c = 3'd4;
      return c;
   endfunction
endpackage

// ----- rtl/core/fce_cmp.sv -----
// Shared time compare unit: one 32-bit subtract, then a compare against a span or a sign test.
`timescale 1ns / 1ps
module fce_cmp (
   input  fce_pkg::cmp_op_type op,
   input  logic [31:0]         now,
   input  logic [31:0]         since,
   input  logic [15:0]         span,
   output logic                hit
);
   import fce_pkg::*;
   logic [31:0] diff;
   assign diff = now - since;
   always_comb begin
      unique case (op)
         CMP_WAITED:  hit = diff >= {16'd0, span};
         CMP_REACHED: hit = ~diff[31];
         CMP_LESS:    hit = diff < {16'd0, span};
         default:     hit = 1'b0;
      endcase
   end
endmodule

// ----- rtl/core/fce_csr.sv -----
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module fce_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output fce_pkg::cfg_type    cfg
);
   import fce_pkg::*;
   cfg_type cfg_ff, cfg_in;
   logic [2:0] idx;
   assign idx = csr_paddr[4:2];
   assign cfg = cfg_ff;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_DEBOUNCE: cfg_in.debounce_time   = csr_pwdata[15:0];
            REG_DTAP:     cfg_in.double_tap_gap  = csr_pwdata[15:0];
            REG_WINDOW:   cfg_in.chord_window    = csr_pwdata[15:0];
            REG_LONG:     cfg_in.long_press_time = csr_pwdata[15:0];
            REG_RDELAY:   cfg_in.repeat_delay    = csr_pwdata[15:0];
            REG_RINTV:    cfg_in.repeat_interval = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (idx)
         REG_DEBOUNCE: csr_prdata = {16'd0, cfg_ff.debounce_time};
         REG_DTAP:     csr_prdata = {16'd0, cfg_ff.double_tap_gap};
         REG_WINDOW:   csr_prdata = {16'd0, cfg_ff.chord_window};
         REG_LONG:     csr_prdata = {16'd0, cfg_ff.long_press_time};
         REG_RDELAY:   csr_prdata = {16'd0, cfg_ff.repeat_delay};
         REG_RINTV:    csr_prdata = {16'd0, cfg_ff.repeat_interval};
         default:      csr_prdata = 32'd0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'd20, 16'd300, 16'd50, 16'd600, 16'd500, 16'd150};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ----- rtl/core/fce_seq.sv -----
// Sequencer that walks one sample through the shared compare unit and emits events.
`timescale 1ns / 1ps
module fce_seq #(
   parameter int MAX_REPEATS = fce_pkg::MaxRepeatsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  fce_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [3:0]       req_raw_switches,
   input  logic [31:0]      req_time_now,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_event_kind,
   output logic [1:0]       rsp_switch_index,
   output logic [2:0]       rsp_chord_code,
   output logic [31:0]      rsp_event_time,
   output logic             rsp_last_event
);
   import fce_pkg::*;
   localparam int RepW = $clog2(MAX_REPEATS + 1);
   localparam int ResW = $clog2(ResultLimit + 1);

   state_type state_ff, state_in, ret_ff, ret_in, wret_ff, wret_in;
   logic [3:0]  raw_ff, raw_in;
   logic [31:0] now_ff, now_in;
   logic        seen_ff, seen_in;
   logic [3:0]  raw_level_ff, raw_level_in;
   logic [31:0] raw_time_ff, raw_time_in;
   logic [3:0]  stable_ff, stable_in;
   logic        win_ff, win_in;
   logic [31:0] win_start_ff, win_start_in;
   logic        chord_ff, chord_in;
   logic [3:0]  cmask_ff, cmask_in;
   logic [2:0]  ccode_ff, ccode_in;
   logic [31:0] due_ff, due_in;
   logic [3:0]  single_ff, single_in;
   logic [3:0]  had_ff, had_in;
   logic [3:0]  lsent_ff, lsent_in;
   logic [31:0] prior_ff [4];
   logic [31:0] pstart_ff [4];
   logic        stamp_we;
   logic [3:0]  walk_ff, walk_in;
   logic [1:0]  bit_ff, bit_in;
   logic [RepW-1:0] rep_ff, rep_in;
   logic [ResW-1:0] cnt_ff, cnt_in;
   // Newly found event, waiting to move into the pending slot.
   logic [2:0]  nk_ff, nk_in;
   logic [1:0]  ns_ff, ns_in;
   logic [2:0]  nc_ff, nc_in;
   // Pending event held back until it is known whether it is the last one.
   logic [2:0]  pk_ff, pk_in;
   logic [1:0]  ps_ff, ps_in;
   logic [2:0]  pc_ff, pc_in;
   logic        pend_ff, pend_in;
   logic        ov_ff, ov_in;
   logic [2:0]  ok_ff, ok_in;
   logic [1:0]  os_ff, os_in;
   logic [2:0]  oc_ff, oc_in;
   logic [31:0] ot_ff, ot_in;
   logic        ol_ff, ol_in;

   cmp_op_type  op;
   logic [31:0] since;
   logic [15:0] span;
   logic        hit;

   fce_cmp u_cmp (.op(op), .now(now_ff), .since(since), .span(span), .hit(hit));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_event_kind = ok_ff;
   assign rsp_switch_index = os_ff;
   assign rsp_chord_code = oc_ff;
   assign rsp_event_time = ot_ff;
   assign rsp_last_event = ol_ff;

   // Compare unit operand selection by state.
   always_comb begin
      op = CMP_WAITED;
      since = raw_time_ff;
      span = cfg.debounce_time;
      unique case (state_ff)
         ST_REPEAT: begin op = CMP_REACHED; since = due_ff; end
         ST_WINDOW: begin since = win_start_ff; span = cfg.chord_window; end
         ST_DTAP:   begin op = CMP_LESS; since = prior_ff[bit_ff];
                          span = cfg.double_tap_gap; end
         ST_LONG:   begin since = pstart_ff[bit_ff]; span = cfg.long_press_time; end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_RAW;
         ST_RAW:    state_in = ST_DEB;
         ST_DEB:    state_in = ST_CHORD;
         ST_CHORD:  if (!chord_ff) state_in = ST_WINDOW;
                    else if (stable_ff != cmask_ff) state_in = ST_EMIT;
                    else state_in = ST_REPEAT;
         ST_REPEAT: if (rep_ff == RepW'(MAX_REPEATS) || !hit) state_in = ST_DONE;
                    else state_in = ST_EMIT;
         ST_WINDOW: if (win_ff && hit && pair_code(stable_ff) != 3'd0) state_in = ST_EMIT;
                    else if (win_ff && hit && stable_ff != 4'd0) state_in = ST_PRESS;
                    else state_in = ST_REL;
         ST_PRESS:  if (walk_ff[bit_ff]) state_in = ST_EMIT;
                    else if (bit_ff == 2'd3) state_in = wret_ff;
                    else state_in = ST_PRESS;
         ST_DTAP:   if (had_ff[bit_ff] && hit) state_in = ST_EMIT;
                    else if (bit_ff == 2'd3) state_in = wret_ff;
                    else state_in = ST_PRESS;
         ST_REL:    if (single_ff[bit_ff] && !stable_ff[bit_ff]) state_in = ST_EMIT;
                    else if (bit_ff == 2'd3) state_in = ST_LONG;
                    else state_in = ST_REL;
         ST_LONG:   if (single_ff[bit_ff] && !lsent_ff[bit_ff] && hit) state_in = ST_EMIT;
                    else if (bit_ff == 2'd3) state_in = ST_ADDED;
                    else state_in = ST_LONG;
         ST_ADDED:  state_in = (single_ff != 4'd0 && (stable_ff & ~single_ff) != 4'd0) ?
                               ST_PRESS : ST_DONE;
         ST_EMIT:   if (!ov_ff || rsp_ready) state_in = ret_ff;
         ST_DONE:   if (!pend_ff) state_in = ST_IDLE;
                    else if (!ov_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of each state.
   always_comb begin
      logic [3:0] added;
      logic [3:0] rel;
      added = stable_ff & ~single_ff;
      rel = single_ff & ~stable_ff;
      raw_in = raw_ff; now_in = now_ff; seen_in = seen_ff;
      raw_level_in = raw_level_ff; raw_time_in = raw_time_ff; stable_in = stable_ff;
      win_in = win_ff; win_start_in = win_start_ff; chord_in = chord_ff;
      cmask_in = cmask_ff; ccode_in = ccode_ff; due_in = due_ff; single_in = single_ff;
      had_in = had_ff; lsent_in = lsent_ff; stamp_we = 1'b0;
      walk_in = walk_ff; bit_in = bit_ff; rep_in = rep_ff; cnt_in = cnt_ff;
      ret_in = ret_ff; wret_in = wret_ff;
      nk_in = nk_ff; ns_in = ns_ff; nc_in = nc_ff;
      pk_in = pk_ff; ps_in = ps_ff; pc_in = pc_ff; pend_in = pend_ff;
      ov_in = ov_ff; ok_in = ok_ff; os_in = os_ff; oc_in = oc_ff; ot_in = ot_ff; ol_in = ol_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            raw_in = req_raw_switches; now_in = req_time_now;
            rep_in = '0; cnt_in = '0; pend_in = 1'b0; bit_in = 2'd0;
         end
         ST_RAW: begin
            if (!seen_ff) begin
               seen_in = 1'b1; raw_level_in = raw_ff; raw_time_in = now_ff;
               if (raw_ff != 4'd0) begin win_in = 1'b1; win_start_in = now_ff; end
            end else if (raw_ff != raw_level_ff) begin
               raw_level_in = raw_ff; raw_time_in = now_ff;
               if (!win_ff && single_ff == 4'd0 && !chord_ff && raw_level_ff == 4'd0
                   && raw_ff != 4'd0) begin
                  win_in = 1'b1; win_start_in = now_ff;
               end
            end
         end
         ST_DEB: if (raw_level_ff != stable_ff && hit) stable_in = raw_level_ff;
         ST_CHORD: if (chord_ff && stable_ff != cmask_ff) begin
            nk_in = EV_CHORD_RELEASE; ns_in = 2'd0; nc_in = ccode_ff; ret_in = ST_DONE;
            chord_in = 1'b0; cmask_in = 4'd0; ccode_in = 3'd0;
            if (stable_ff != 4'd0) begin win_in = 1'b1; win_start_in = now_ff; end
         end
         ST_REPEAT: if (rep_ff != RepW'(MAX_REPEATS) && hit) begin
            nk_in = EV_CHORD_REPEAT; ns_in = 2'd0; nc_in = ccode_ff; ret_in = ST_REPEAT;
            due_in = due_ff + {16'd0, cfg.repeat_interval}; rep_in = rep_ff + RepW'(1);
         end
         ST_WINDOW: begin
            bit_in = 2'd0;
            if (win_ff && hit) begin
               win_in = 1'b0;
               if (pair_code(stable_ff) != 3'd0) begin
                  chord_in = 1'b1; cmask_in = stable_ff; ccode_in = pair_code(stable_ff);
                  due_in = now_ff + {16'd0, cfg.repeat_delay};
                  nk_in = EV_CHORD_PRESS; ns_in = 2'd0; nc_in = pair_code(stable_ff);
                  ret_in = ST_REL;
               end else if (stable_ff != 4'd0) begin
                  single_in = stable_ff; walk_in = stable_ff; wret_in = ST_REL;
               end
            end
         end
         ST_PRESS: begin
            if (walk_ff[bit_ff]) begin
               nk_in = EV_PRESS; ns_in = bit_ff; nc_in = 3'd0; ret_in = ST_DTAP;
            end else bit_in = bit_ff + 2'd1;
         end
         ST_DTAP: begin
            if (had_ff[bit_ff] && hit) begin
               nk_in = EV_DOUBLE; ns_in = bit_ff; nc_in = 3'd0;
            end
            had_in[bit_ff] = 1'b1; lsent_in[bit_ff] = 1'b0; stamp_we = 1'b1;
            walk_in[bit_ff] = 1'b0;
            bit_in = bit_ff + 2'd1;
            ret_in = (bit_ff == 2'd3) ? wret_ff : ST_PRESS;
         end
         ST_REL: begin
            if (single_ff[bit_ff] && !stable_ff[bit_ff]) begin
               nk_in = EV_RELEASE; ns_in = bit_ff; nc_in = 3'd0;
               ret_in = (bit_ff == 2'd3) ? ST_LONG : ST_REL;
            end
            if (bit_ff == 2'd3) single_in = single_ff & ~rel;
            bit_in = bit_ff + 2'd1;
         end
         ST_LONG: begin
            if (single_ff[bit_ff] && !lsent_ff[bit_ff] && hit) begin
               nk_in = EV_LONG; ns_in = bit_ff; nc_in = 3'd0; lsent_in[bit_ff] = 1'b1;
               ret_in = (bit_ff == 2'd3) ? ST_ADDED : ST_LONG;
            end
            bit_in = bit_ff + 2'd1;
         end
         ST_ADDED: begin
            bit_in = 2'd0;
            if (single_ff != 4'd0 && added != 4'd0) begin
               single_in = single_ff | added; walk_in = added; wret_in = ST_DONE;
            end
         end
         default: ;
      endcase
      // A new event sends the previous pending one out and takes its place.
      // Events past the result limit are dropped.
      if (state_ff == ST_EMIT && (!ov_ff || rsp_ready) && cnt_ff != ResW'(ResultLimit)) begin
         if (pend_ff) begin
            ov_in = 1'b1; ok_in = pk_ff; os_in = ps_ff; oc_in = pc_ff;
            ot_in = now_ff; ol_in = 1'b0;
         end
         pk_in = nk_ff; ps_in = ns_ff; pc_in = nc_ff;
         pend_in = 1'b1; cnt_in = cnt_ff + ResW'(1);
      end
      if (state_ff == ST_DONE && pend_ff && (!ov_ff || rsp_ready)) begin
         ov_in = 1'b1; ok_in = pk_ff; os_in = ps_ff; oc_in = pc_ff;
         ot_in = now_ff; ol_in = 1'b1; pend_in = 1'b0;
      end
   end

   // Per-switch time stamps and the other registers without reset.
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         prior_ff[bit_ff] <= now_ff;
         pstart_ff[bit_ff] <= now_ff;
      end
      raw_ff <= raw_in; now_ff <= now_in; raw_time_ff <= raw_time_in;
      win_start_ff <= win_start_in; due_ff <= due_in;
      nk_ff <= nk_in; ns_ff <= ns_in; nc_ff <= nc_in;
      pk_ff <= pk_in; ps_ff <= ps_in; pc_ff <= pc_in;
      ok_ff <= ok_in; os_ff <= os_in; oc_ff <= oc_in; ot_ff <= ot_in; ol_ff <= ol_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ret_ff <= ST_DONE; wret_ff <= ST_DONE;
         seen_ff <= 1'b0; raw_level_ff <= 4'd0;
         stable_ff <= 4'd0; win_ff <= 1'b0; chord_ff <= 1'b0; cmask_ff <= 4'd0;
         ccode_ff <= 3'd0; single_ff <= 4'd0; had_ff <= 4'd0; lsent_ff <= 4'd0;
         walk_ff <= 4'd0; bit_ff <= 2'd0; rep_ff <= '0; cnt_ff <= '0;
         pend_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; wret_ff <= wret_in; seen_ff <= seen_in;
         raw_level_ff <= raw_level_in; stable_ff <= stable_in; win_ff <= win_in;
         chord_ff <= chord_in; cmask_ff <= cmask_in; ccode_ff <= ccode_in;
         single_ff <= single_in; had_ff <= had_in; lsent_ff <= lsent_in;
         walk_ff <= walk_in; bit_ff <= bit_in; rep_ff <= rep_in; cnt_ff <= cnt_in;
         pend_ff <= pend_in; ov_ff <= ov_in;
      end
   end
endmodule

// ----- rtl/core/footswitch_chord_event_engine.sv -----
// Top level of the footswitch chord event engine.
`timescale 1ns / 1ps
// One sample item is taken when req_ready is high; the block then works on it
// alone and takes no new item until it is done, also while the output register
// waits on rsp_ready. The sequencer walks over the four switches, with all time
// checks going through one shared 32-bit subtract-and-compare unit, and req_ready
// returns after the last event of the item has entered the output register.
module footswitch_chord_event_engine #(
   parameter int MAX_REPEATS = fce_pkg::MaxRepeatsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_raw_switches,
   input  logic [31:0] req_time_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [1:0]  rsp_switch_index,
   output logic [2:0]  rsp_chord_code,
   output logic [31:0] rsp_event_time,
   output logic        rsp_last_event,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fce_pkg::*;
   cfg_type cfg;
   assign csr_pready = 1'b1;
   fce_csr u_csr (
      .clock(clock), .reset(reset), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .cfg(cfg)
   );
   fce_seq #(.MAX_REPEATS(MAX_REPEATS)) u_seq (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_raw_switches(req_raw_switches), .req_time_now(req_time_now),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_event_kind(rsp_event_kind),
      .rsp_switch_index(rsp_switch_index), .rsp_chord_code(rsp_chord_code),
      .rsp_event_time(rsp_event_time), .rsp_last_event(rsp_last_event)
   );
endmodule

// ----- rtl/core/fce_checker.sv -----
// Port-level checker for the footswitch chord event engine and its bind.
`timescale 1ns / 1ps
`include "footswitch_chord_event_engine_defines.svh"
module fce_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_kind,
   input logic [2:0]  rsp_chord_code,
   input logic        csr_pready
);
   import fce_pkg::*;
   `FCE_ASSERT_IMPL(a_kind_range, clock, reset, rsp_valid, rsp_event_kind != 3'd7)
   `FCE_ASSERT_IMPL(a_chord_code, clock, reset,
      rsp_valid && (rsp_event_kind == EV_PRESS || rsp_event_kind == EV_RELEASE),
      rsp_chord_code == 3'd0)
   `FCE_ASSERT_IMPL(a_pready, clock, reset, 1'b1, csr_pready)
   `FCE_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `FCE_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind footswitch_chord_event_engine fce_checker u_fce_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_event_kind(rsp_event_kind),
   .rsp_chord_code(rsp_chord_code), .csr_pready(csr_pready)
);
